// File: hdl/generational_handle_table_top_assert.svh
// ----------------------------------------------------------------------------
// generational handle table assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define GHT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// types and codes shared by the generational handle table modules
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 10;
    localparam int VER_W  = 32;
    localparam int COMP_W = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SPAWN    = 3'd0,
        FUNC_DESPAWN  = 3'd1,
        FUNC_IS_VALID = 3'd2,
        FUNC_ASSIGN   = 3'd3,
        FUNC_REMOVE   = 3'd4,
        FUNC_HAS      = 3'd5,
        FUNC_CLEAR    = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_QFULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  entity_index;
        logic [VER_W-1:0]  entity_version;
        logic [COMP_W-1:0] component_id;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] handle_index;
        logic [VER_W-1:0] handle_version;
        logic             answer;
        status_t          status;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_EXEC  = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic commit;
    } ght_cmd_t;

    typedef struct packed {
        logic pop_needed;
        logic out_free;
    } ght_stat_t;

endpackage

// File: hdl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer: capture, optional freed-index fetch, execute and commit
// ----------------------------------------------------------------------------
module ght_ctrl
    import ght_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ght_stat_t stat,
    output ght_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = stat.pop_needed ? S_FETCH : S_EXEC;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ght_dp.sv
// ----------------------------------------------------------------------------
// ght_dp
// entry and free-queue memories, table counters and result register
// ----------------------------------------------------------------------------
module ght_dp
    import ght_pkg::*;
#(
    parameter int MAX_ENTRIES  = 1024,
    parameter int VERSION_BITS = 32,
    parameter int MASK_BITS    = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_payload,
    input  ght_cmd_t  cmd,
    output ght_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int VW = VERSION_BITS;
    localparam int MB = MASK_BITS;

    typedef struct packed {
        logic          live;
        logic [VW-1:0] version;
        logic [MB-1:0] mask;
    } entry_t;

    entry_t         entry_mem [MAX_ENTRIES];
    logic [IW-1:0]  queue_mem [MAX_ENTRIES];

    entry_t         entry_rd_reg;
    logic [IW-1:0]  queue_rd_reg;
    in_item_t       op_reg;

    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  head_reg, head_next;
    logic [IW-1:0]  tail_reg, tail_next;
    logic           m_valid_reg, m_valid_next;
    out_item_t      result_reg, result_next;

    logic           entry_rd_en;
    logic [IW-1:0]  entry_ra;
    logic           entry_we;
    logic [IW-1:0]  entry_wa;
    entry_t         entry_wd;
    logic           queue_we;

    logic [IW-1:0]  idx_w;
    logic [VW-1:0]  ver;
    logic           in_range;
    logic           comp_ok;
    logic           handle_ok;
    logic [MB-1:0]  bit_sel;

    // memory access
    assign entry_rd_en = cmd.capture | cmd.fetch;
    assign entry_ra    = cmd.fetch ? queue_rd_reg : IW'(s_payload.entity_index);

    always_ff @(posedge aclk) begin
        if (entry_rd_en) begin
            entry_rd_reg <= entry_mem[entry_ra];
        end
        if (entry_we) begin
            entry_mem[entry_wa] <= entry_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            queue_rd_reg <= queue_mem[head_reg];
        end
        if (queue_we) begin
            queue_mem[tail_reg] <= idx_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_payload;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            count_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operation decode
    assign idx_w     = IW'(op_reg.entity_index);
    assign ver       = op_reg.entity_version[VW-1:0];
    assign in_range  = 32'(op_reg.entity_index) < 32'(used_reg);
    assign comp_ok   = 32'(op_reg.component_id) < 32'(MB);
    assign handle_ok = in_range && entry_rd_reg.live && (entry_rd_reg.version == ver);

    always_comb begin
        for (int i = 0; i < MB; i++) begin
            bit_sel[i] = (32'(op_reg.component_id) == 32'(i));
        end
    end

    always_comb begin
        used_next   = used_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        entry_we    = 1'b0;
        entry_wa    = idx_w;
        entry_wd    = entry_rd_reg;
        queue_we    = 1'b0;
        result_next = '0;
        result_next.status = ST_OK;
        if (cmd.commit) begin
            case (op_reg.func)
                FUNC_SPAWN: begin
                    if (count_reg != '0) begin
                        entry_we      = 1'b1;
                        entry_wa      = queue_rd_reg;
                        entry_wd.live = 1'b1;
                        head_next     = (head_reg == IW'(MAX_ENTRIES - 1)) ? '0
                                                                          : head_reg + 1'b1;
                        count_next    = count_reg - 1'b1;
                        result_next.handle_index   = IDX_W'(queue_rd_reg);
                        result_next.handle_version = VER_W'(entry_rd_reg.version);
                    end else if (used_reg == CW'(MAX_ENTRIES)) begin
                        result_next.status = ST_FULL;
                    end else begin
                        entry_we      = 1'b1;
                        entry_wa      = IW'(used_reg);
                        entry_wd      = '0;
                        entry_wd.live = 1'b1;
                        used_next     = used_reg + 1'b1;
                        result_next.handle_index = IDX_W'(used_reg);
                    end
                end
                FUNC_DESPAWN: begin
                    if (!in_range) begin
                        result_next.status = ST_RANGE;
                    end else if (count_reg == CW'(MAX_ENTRIES)) begin
                        result_next.status = ST_QFULL;
                    end else begin
                        entry_we         = 1'b1;
                        entry_wd         = '0;
                        entry_wd.version = ver + 1'b1;
                        queue_we         = 1'b1;
                        tail_next        = (tail_reg == IW'(MAX_ENTRIES - 1)) ? '0
                                                                             : tail_reg + 1'b1;
                        count_next       = count_reg + 1'b1;
                    end
                end
                FUNC_IS_VALID: begin
                    if (!in_range) begin
                        result_next.status = ST_RANGE;
                    end else begin
                        result_next.answer = handle_ok;
                    end
                end
                FUNC_ASSIGN, FUNC_REMOVE, FUNC_HAS: begin
                    if (!in_range || !comp_ok) begin
                        result_next.status = ST_RANGE;
                    end else if (handle_ok) begin
                        if (op_reg.func == FUNC_ASSIGN) begin
                            entry_we           = 1'b1;
                            entry_wd.mask      = entry_rd_reg.mask | bit_sel;
                            result_next.answer = 1'b1;
                        end else if (op_reg.func == FUNC_REMOVE) begin
                            entry_we           = 1'b1;
                            entry_wd.mask      = entry_rd_reg.mask & ~bit_sel;
                            result_next.answer = 1'b1;
                        end else begin
                            result_next.answer = |(entry_rd_reg.mask & bit_sel);
                        end
                    end
                end
                FUNC_CLEAR: begin
                    used_next  = '0;
                    count_next = '0;
                    head_next  = '0;
                    tail_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign stat.pop_needed = (s_payload.func == FUNC_SPAWN) && (count_reg != '0);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

endmodule

// File: hdl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// versioned handle table with per-entry component mask and freed-index fifo
//
//   channel  | ports                        | transfer
//   ---------+------------------------------+------------------------------
//   input    | s_valid s_ready s_payload    | one operation
//   result   | m_valid m_ready m_payload    | one result per operation
//
// capture then execute per operation; a spawn that reuses a freed index adds a fetch state
// between them (queue read, then dependent entry memory read through its single read port).
// reset clears counters, fifo pointers, the result valid flag and the sequencer state; no memory clearing pass.
// a new operation is taken while a result waits in the output register;
// execution holds in the execute state until that register is free.
// ----------------------------------------------------------------------------
module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int MAX_ENTRIES  = 1024,
    parameter int VERSION_BITS = 32,
    parameter int MASK_BITS    = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    ght_cmd_t  cmd;
    ght_stat_t stat;

    ght_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ght_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .VERSION_BITS (VERSION_BITS),
        .MASK_BITS    (MASK_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: hdl/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// port-level checks for the generational handle table
// ----------------------------------------------------------------------------
`include "generational_handle_table_top_assert.svh"

module ght_checker
    import ght_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_payload
);

    `GHT_ASSERT_NEXT(a_result_held, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_payload),
        "result changed while stalled")
    `GHT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn,
        s_valid && s_ready, !s_ready,
        "operation taken in back-to-back cycles")
    `GHT_ASSERT_NOW(a_flag_no_handle, aclk, aresetn,
        m_valid && (m_payload.status != ST_OK),
        (m_payload.handle_index == '0) && (m_payload.handle_version == '0) && !m_payload.answer,
        "flagged result carries data")
    `GHT_ASSERT_NOW(a_answer_no_handle, aclk, aresetn,
        m_valid && m_payload.answer,
        (m_payload.handle_index == '0) && (m_payload.handle_version == '0),
        "answer with handle")

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (.*);

// File: verif/tb_generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_table_top
// self-checking bench for the generational handle table: a short table of
// directed operations, then random traffic that mostly targets live handles,
// with a full-table fill mixed in. every result is compared in order, against the
// directed step's typed expectation or a behavioral copy of the table in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_table_top;
    import ght_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int RANDOM_OPS  = 450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 16;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
        logic [VER_W-1:0]  ver;
        logic [COMP_W-1:0] comp;
        logic              typed;
        logic [IDX_W-1:0]  e_idx;
        logic [VER_W-1:0]  e_ver;
        logic              e_ans;
        status_t           e_st;
    } step_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    // behavioral table
    bit               tbl_live [TABLE_DEPTH];
    logic [VER_W-1:0] tbl_ver  [TABLE_DEPTH];
    logic [63:0]      tbl_mask [TABLE_DEPTH];
    int               freed_idx [TABLE_DEPTH];
    int               tbl_used;
    int               freed_head;
    int               freed_tail;
    int               freed_count;

    out_item_t pending_results [$];
    int        ops_sent;
    int        results_seen;
    int        fail_count;
    int        reuse_count;
    int        full_count;
    int        qfull_count;
    int        cycles;
    bit        calm;

    step_t dir_steps [27] = '{
        '{FUNC_IS_VALID, 10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_RANGE},
        '{FUNC_DESPAWN,  10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_RANGE},
        '{FUNC_SPAWN,    10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_SPAWN,    10'd0,    32'd0,           6'd0,  1'b1, 10'd1, 32'd0, 1'b0, ST_OK},
        '{FUNC_IS_VALID, 10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b1, ST_OK},
        '{FUNC_IS_VALID, 10'd0,    32'd5,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_ASSIGN,   10'd0,    32'd0,           6'd63, 1'b1, 10'd0, 32'd0, 1'b1, ST_OK},
        '{FUNC_HAS,      10'd0,    32'd0,           6'd63, 1'b1, 10'd0, 32'd0, 1'b1, ST_OK},
        '{FUNC_HAS,      10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_ASSIGN,   10'd0,    32'd0,           6'd0,  1'b0, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_REMOVE,   10'd0,    32'd0,           6'd63, 1'b1, 10'd0, 32'd0, 1'b1, ST_OK},
        '{FUNC_HAS,      10'd0,    32'd0,           6'd63, 1'b0, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_ASSIGN,   10'd1,    32'd7,           6'd5,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_REMOVE,   10'd1,    32'hFFFF_FFFF,   6'd63, 1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_ASSIGN,   10'd1023, 32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_RANGE},
        '{FUNC_HAS,      10'd2,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_RANGE},
        '{FUNC_DESPAWN,  10'd0,    32'hFFFF_FFFF,   6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_IS_VALID, 10'd0,    32'd0,           6'd0,  1'b0, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_HAS,      10'd0,    32'd0,           6'd0,  1'b0, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_SPAWN,    10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_HAS,      10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_DESPAWN,  10'd1,    32'h8000_1234,   6'd0,  1'b0, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_SPAWN,    10'd0,    32'd0,           6'd0,  1'b1, 10'd1, 32'h8000_1235,
          1'b0, ST_OK},
        '{FUNC_UNUSED,   10'd5,    32'hA5A5_A5A5,   6'd42, 1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_CLEAR,    10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK},
        '{FUNC_IS_VALID, 10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_RANGE},
        '{FUNC_SPAWN,    10'd0,    32'd0,           6'd0,  1'b1, 10'd0, 32'd0, 1'b0, ST_OK}
    };

    generational_handle_table_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void table_wipe();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_live[i] = 1'b0;
        end
        tbl_used    = 0;
        freed_head  = 0;
        freed_tail  = 0;
        freed_count = 0;
    endfunction

    function automatic void queue_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic out_item_t table_apply(in_item_t op);
        out_item_t        r;
        int               idx;
        int               k;
        logic [VER_W-1:0] ver;
        bit               in_range;
        bit               good;
        r        = '0;
        idx      = int'(op.entity_index);
        ver      = op.entity_version;
        in_range = idx < tbl_used;
        good     = in_range && tbl_live[idx] && tbl_ver[idx] == ver;
        case (op.func)
            FUNC_SPAWN: begin
                if (freed_count > 0) begin
                    k = freed_idx[freed_head];
                    freed_head = (freed_head + 1) % TABLE_DEPTH;
                    freed_count--;
                    tbl_live[k] = 1'b1;
                    r.handle_index = IDX_W'(k);
                    r.handle_version = tbl_ver[k];
                    reuse_count++;
                end else if (tbl_used >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                    full_count++;
                end else begin
                    k = tbl_used;
                    tbl_used++;
                    tbl_live[k] = 1'b1;
                    tbl_ver[k]  = '0;
                    tbl_mask[k] = '0;
                    r.handle_index = IDX_W'(k);
                end
            end
            FUNC_DESPAWN: begin
                if (!in_range) begin
                    r.status = ST_RANGE;
                end else if (freed_count >= TABLE_DEPTH) begin
                    r.status = ST_QFULL;
                    qfull_count++;
                end else begin
                    tbl_live[idx] = 1'b0;
                    tbl_ver[idx]  = ver + 1'b1;
                    tbl_mask[idx] = '0;
                    freed_idx[freed_tail] = idx;
                    freed_tail = (freed_tail + 1) % TABLE_DEPTH;
                    freed_count++;
                end
            end
            FUNC_IS_VALID: begin
                if (!in_range) r.status = ST_RANGE;
                else r.answer = good;
            end
            FUNC_ASSIGN, FUNC_REMOVE, FUNC_HAS: begin
                if (!in_range) begin
                    r.status = ST_RANGE;
                end else if (good) begin
                    if (op.func == FUNC_ASSIGN) begin
                        tbl_mask[idx][op.component_id] = 1'b1;
                        r.answer = 1'b1;
                    end else if (op.func == FUNC_REMOVE) begin
                        tbl_mask[idx][op.component_id] = 1'b0;
                        r.answer = 1'b1;
                    end else begin
                        r.answer = tbl_mask[idx][op.component_id];
                    end
                end
            end
            FUNC_CLEAR: table_wipe();
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t make_op(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                         logic [VER_W-1:0] ver, logic [COMP_W-1:0] comp);
        in_item_t op;
        op.func           = f;
        op.entity_index   = idx;
        op.entity_version = ver;
        op.component_id   = comp;
        return op;
    endfunction

    // mostly live handles with their current version, some near misses, some noise
    function automatic in_item_t random_op();
        in_item_t         op;
        int               r;
        int               pick;
        int               start;
        int               j;
        logic [IDX_W-1:0] idx;
        logic [VER_W-1:0] ver;
        r = $urandom_range(0, 99);
        op.component_id = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (tbl_used == 0 || pick >= 85) begin
            idx = 10'($urandom());
            ver = $urandom_range(0, 1) ? 32'($urandom()) : 32'($urandom_range(0, 3));
        end else if (pick < 70) begin
            start = $urandom_range(0, tbl_used - 1);
            idx = IDX_W'(start);
            ver = tbl_ver[start];
            for (int k = 0; k < tbl_used; k++) begin
                j = (start + k) % tbl_used;
                if (tbl_live[j]) begin
                    idx = IDX_W'(j);
                    ver = tbl_ver[j];
                    break;
                end
            end
        end else begin
            idx = IDX_W'($urandom_range(0, tbl_used - 1));
            ver = tbl_ver[idx] + 32'($urandom_range(0, 1));
        end
        op.entity_index   = idx;
        op.entity_version = ver;
        if (r < 20) begin
            op.func = FUNC_SPAWN;
        end else if (r < 35) begin
            op.func = FUNC_DESPAWN;
            if ($urandom_range(0, 4) == 0) begin
                op.entity_version = $urandom_range(0, 1) ? 32'($urandom()) : 32'hFFFF_FFFF;
            end
        end else if (r < 50) begin
            op.func = FUNC_IS_VALID;
        end else if (r < 65) begin
            op.func = FUNC_ASSIGN;
        end else if (r < 78) begin
            op.func = FUNC_REMOVE;
        end else if (r < 95) begin
            op.func = FUNC_HAS;
        end else if (r < 96) begin
            op.func = FUNC_CLEAR;
        end else begin
            j = $urandom_range(0, 6);
            op.func           = (j == 6) ? FUNC_UNUSED : 3'(j);
            op.entity_index   = 10'($urandom());
            op.entity_version = 32'($urandom());
            op.component_id   = 6'($urandom());
        end
        return op;
    endfunction

    task automatic issue(input in_item_t op, input bit typed = 1'b0,
                         input out_item_t typed_res = '0);
        int        gap;
        out_item_t predicted;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= op;
        do @(posedge aclk); while (!s_ready);
        predicted = table_apply(op);
        queue_result(typed ? typed_res : predicted);
        ops_sent++;
        if (ops_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
    endtask

    task automatic fill_table();
        issue(make_op(FUNC_CLEAR, '0, '0, '0));
        repeat (TABLE_DEPTH + 2) issue(make_op(FUNC_SPAWN, '0, '0, '0));
    endtask

    // result channel
    initial begin
        int        stall;
        out_item_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result transfer: idx %0d ver %h ans %0d st %0d",
                        m_payload.handle_index, m_payload.handle_version,
                        m_payload.answer, m_payload.status);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_payload.handle_index !== want.handle_index ||
                    m_payload.handle_version !== want.handle_version ||
                    m_payload.answer !== want.answer ||
                    m_payload.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at result %0d: exp idx %0d ver %h ans %0d st %0d",
                            results_seen, want.handle_index, want.handle_version,
                            want.answer, want.status);
                        $display("                          got idx %0d ver %h ans %0d st %0d",
                            m_payload.handle_index, m_payload.handle_version,
                            m_payload.answer, m_payload.status);
                    end
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        step_t st;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        calm      = 1'b0;
        table_wipe();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_steps[i]) begin
            st = dir_steps[i];
            issue(make_op(st.func, st.idx, st.ver, st.comp), st.typed,
                  out_item_t'({st.e_idx, st.e_ver, st.e_ans, st.e_st}));
        end

        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i == RANDOM_OPS / 3) fill_table();
            issue(random_op());
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("%0d operations sent, %0d results checked, %0d failures", ops_sent,
            results_seen, fail_count);
        $display("freed-index reuse %0d, table full %0d, free queue full %0d", reuse_count,
            full_count, qfull_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
